>>> design/b2dd_pkg.sv
package b2dd_pkg;

  // Default depth of the digit buffer
  localparam int unsigned MaxDigitsDef = 10;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 6;
  localparam int unsigned DigitW = 4;

  // ASCII code of '0'
  localparam logic [CharW-1:0] AsciiZero = 6'd48;

  // Reciprocal of ten: q = (x * RecipMagic) >> RecipShift, exact for any 32-bit x
  localparam logic [31:0] RecipMagic = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StEmit = 3'b100
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture a new value
    logic step;  // divide by ten, store one digit
    logic pop;   // advance to the next less significant digit
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic quot_zero;  // the quotient of the current step is zero
    logic last;       // the digit on the output is the final one
  } dp_sts_t;

endpackage

>>> design/b2dd_ctrl.sv
module b2dd_ctrl
  import b2dd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_neg_i,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // negative input skips conversion: one error result
          state_d    = in_neg_i ? StEmit : StConv;
        end
      end
      StConv: begin
        cmd_o.step = 1'b1;
        if (sts_i.quot_zero) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.last) begin
            state_d = StIdle;
          end else begin
            cmd_o.pop = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

>>> design/b2dd_datapath.sv
module b2dd_datapath
  import b2dd_pkg::*;
#(
  parameter int unsigned MaxDigits = MaxDigitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [ValueW-1:0] value_i,
  output dp_sts_t           sts_o,
  output logic [CharW-1:0]  digit_char_o,
  output logic              status_o
);

  localparam int unsigned CntW  = $clog2(MaxDigits + 1);
  localparam int unsigned IdxW  = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
  localparam int unsigned RestW = ValueW - 1;
  localparam int unsigned ProdW = RestW + 32;

  logic [RestW-1:0]  rest_q;
  logic [CntW-1:0]   cnt_q;
  logic [IdxW-1:0]   rd_q;
  logic              err_q;
  logic [DigitW-1:0] buf_q [MaxDigits];

  logic [ProdW-1:0]  prod;
  logic [RestW-1:0]  quot;
  logic [RestW-1:0]  quot_x10;
  logic [RestW-1:0]  rem_full;
  logic [DigitW-1:0] rem;
  logic              has_room;
  logic [CntW-1:0]   cnt_next;
  logic [CntW-1:0]   top_idx;

  // divide by ten through the reciprocal, remainder by shift-add
  assign prod     = ProdW'(rest_q) * ProdW'(RecipMagic);
  assign quot     = RestW'(prod[ProdW-1:RecipShift]);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_full = rest_q - quot_x10;
  assign rem      = rem_full[DigitW-1:0];

  assign has_room = (cnt_q < CntW'(MaxDigits));
  assign cnt_next = has_room ? cnt_q + CntW'(1) : cnt_q;
  assign top_idx  = cnt_next - CntW'(1);

  // reset-free payload state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rest_q <= value_i[RestW-1:0];
      err_q  <= value_i[ValueW-1];
    end else if (cmd_i.step) begin
      rest_q <= quot;
      if (has_room) begin
        buf_q[cnt_q[IdxW-1:0]] <= rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_next;
      rd_q  <= top_idx[IdxW-1:0];
    end else if (cmd_i.pop) begin
      rd_q  <= rd_q - IdxW'(1);
    end
  end

  assign sts_o.quot_zero = (quot == '0);
  assign sts_o.last      = err_q || (rd_q == '0);

  assign digit_char_o = err_q ? AsciiZero : AsciiZero + CharW'(buf_q[rd_q]);
  assign status_o     = err_q;

endmodule

>>> design/binary_to_decimal_digits_top.sv
// Operation: the value is taken, the divide-by-ten unit produces its decimal digits, and then
// the digits are emitted, most significant first; at most 10 digits.
// Throughput: one value at a time; a negative value is accepted and gives one error result.
// The digit loop is a single reciprocal multiplier that yields one digit per cycle.
// Reset (rst_ni, asynchronous, active low) returns the controller to idle and clears counters.
module binary_to_decimal_digits_top
  import b2dd_pkg::*;
#(
  parameter int unsigned MaxDigits = MaxDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value (signed)
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [5:0] digit_char, [7:6] zero
  output logic        m_axis_tlast_o,   // last digit of the number, or error result
  output logic        m_axis_tuser_o    // [0] status: 1 = negative input
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [CharW-1:0] digit_char;
  logic             status;

  // Sequence the transactions: take a value, convert, then hand out digits
  b2dd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_neg_i    (s_axis_tdata_i[ValueW-1]),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (cmd)
  );

  // Divide by ten repeatedly, store digits least significant first, read them back reversed
  b2dd_datapath #(
    .MaxDigits (MaxDigits)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (s_axis_tdata_i),
    .sts_o        (sts),
    .digit_char_o (digit_char),
    .status_o     (status)
  );

  // Hold the digit on the bus until the transaction completes
  assign m_axis_tdata_o = {2'b00, digit_char};
  assign m_axis_tlast_o = sts.last;
  assign m_axis_tuser_o = status;

endmodule
